@@ hdl/tgsl_pkg.sv @@
// Shared types, widths, register codes and reset values of the setpoint slew limiter.
package tgsl_pkg;

  localparam int AngleWidth  = 16;
  localparam int CfgWidth    = 15;
  localparam int CfgIdxWidth = 3;
  localparam int MagWidth    = AngleWidth - 1;
  localparam int ProdWidth   = MagWidth + CfgWidth;
  localparam int ExtWidth    = AngleWidth + 2;
  localparam int DivCntWidth = $clog2(MagWidth);

  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef logic signed [ExtWidth-1:0]   ext_t;
  typedef logic [CfgWidth-1:0]          cfg_word_t;
  typedef logic [CfgIdxWidth-1:0]       cfg_idx_t;

  // register indexes
  localparam cfg_idx_t RegMaxSetpoint = cfg_idx_t'(0);
  localparam cfg_idx_t RegMaxTilt     = cfg_idx_t'(1);
  localparam cfg_idx_t RegGuardBand   = cfg_idx_t'(2);
  localparam cfg_idx_t RegMaxStep     = cfg_idx_t'(3);
  localparam cfg_idx_t RegBypass      = cfg_idx_t'(4);

  localparam cfg_word_t RstMaxSetpoint = cfg_word_t'(2560);
  localparam cfg_word_t RstMaxTilt     = cfg_word_t'(7680);
  localparam cfg_word_t RstGuardBand   = cfg_word_t'(1280);
  localparam cfg_word_t RstMaxStep     = cfg_word_t'(51);

  typedef struct packed {
    cfg_word_t max_setpoint;
    cfg_word_t max_tilt;
    cfg_word_t guard_band;
    cfg_word_t step_limit;
    logic      bypass;
  } cfg_t;

endpackage

@@ hdl/tgsl_if.sv @@
// Handshake channels of the setpoint slew limiter: input beats, result beats, register writes.
interface tgsl_in_if;
  import tgsl_pkg::*;
  logic   valid;
  logic   ready;
  angle_t setpoint_in;
  angle_t pitch_meas;
  modport source (output valid, output setpoint_in, output pitch_meas, input ready);
  modport sink   (input valid, input setpoint_in, input pitch_meas, output ready);
endinterface

interface tgsl_out_if;
  import tgsl_pkg::*;
  logic   valid;
  logic   ready;
  angle_t setpoint_out;
  modport source (output valid, output setpoint_out, input ready);
  modport sink   (input valid, input setpoint_out, output ready);
endinterface

interface tgsl_cfg_if;
  import tgsl_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_word_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/tgsl_cfg_regs.sv @@
// Configuration register bank of the setpoint slew limiter.
module tgsl_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  tgsl_cfg_if.sink      cfg_i,
  output tgsl_pkg::cfg_t cfg_o
);
  import tgsl_pkg::*;

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.max_setpoint <= RstMaxSetpoint;
      regs_q.max_tilt     <= RstMaxTilt;
      regs_q.guard_band   <= RstGuardBand;
      regs_q.step_limit   <= RstMaxStep;
      regs_q.bypass       <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegMaxSetpoint: regs_q.max_setpoint <= cfg_i.data;
        RegMaxTilt:     regs_q.max_tilt     <= cfg_i.data;
        RegGuardBand:   regs_q.guard_band   <= cfg_i.data;
        RegMaxStep:     regs_q.step_limit   <= cfg_i.data;
        RegBypass:      regs_q.bypass       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/tgsl_div.sv @@
// Restoring divider, one quotient bit per cycle, for the guard band attenuation.
module tgsl_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tgsl_pkg::ProdWidth-1:0] dividend_i,
  input  tgsl_pkg::cfg_word_t            divisor_i,
  output logic                           done_o,
  output logic [tgsl_pkg::MagWidth-1:0]  quotient_o
);
  import tgsl_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  cfg_word_t              rem_q, rem_d;
  cfg_word_t              div_q, div_d;
  logic [MagWidth-1:0]    dvd_q, dvd_d;
  logic [MagWidth-1:0]    quo_q, quo_d;
  logic [CfgWidth:0]      shifted;
  logic [CfgWidth+1:0]    trial;
  logic                   fits;

  // upper dividend bits start below the divisor, so the remainder stays CfgWidth wide
  assign shifted = {rem_q, dvd_q[MagWidth-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_q};
  assign fits    = ~trial[CfgWidth+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[ProdWidth-1:MagWidth];
      dvd_d  = dividend_i[MagWidth-1:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[CfgWidth-1:0] : shifted[CfgWidth-1:0];
      dvd_d = {dvd_q[MagWidth-2:0], 1'b0};
      quo_d = {quo_q[MagWidth-2:0], fits};
      cnt_d = cnt_q + DivCntWidth'(1);
      if (cnt_q == DivCntWidth'(MagWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/tilt_guarded_setpoint_slew_limiter.sv @@
// Top level of the tilt-guarded pitch setpoint slew limiter: sequencer and datapath.
//
//  channel  dir  payload                          beat when
//  in_i     in   setpoint_in, pitch_meas          in_i.valid & in_i.ready
//  out_o    out  setpoint_out                     out_o.valid & out_o.ready
//  cfg_i    in   index, data (15 bits)            cfg_i.valid & cfg_i.ready
//
// One input beat at a time. From acceptance to ready again it passes GUARD and OUT
// in bypass, GUARD, SLEW and OUT without a division, and GUARD, MUL, DIV, SLEW and
// OUT inside the guard band, where DIV waits for the divider's 15 one-bit steps.
// The result sits in an output register, so a new beat is taken while it waits;
// a still-full output register holds the sequencer in its last state.
// Reset clears the held setpoint to zero and the registers to their defaults.
// cfg_i is always ready; writes to indexes past the bypass register are dropped.
module tilt_guarded_setpoint_slew_limiter (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgsl_in_if.sink    in_i,
  tgsl_out_if.source out_o,
  tgsl_cfg_if.sink   cfg_i
);
  import tgsl_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GUARD = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SLEW  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  cfg_t cfg;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  angle_t              out_q, out_d;
  angle_t              req_q, req_d;
  angle_t              meas_q, meas_d;
  angle_t              gd_q, gd_d;
  angle_t              held_q, held_d;
  angle_t              res_q, res_d;
  logic [MagWidth-1:0] mag_q, mag_d;
  cfg_word_t           dist_q, dist_d;
  logic                neg_q, neg_d;

  // guard stage signals
  ext_t      req_x, meas_x, lim_x, tilt_x, band_x, raw_x, raw_neg_x;
  ext_t      dist_pos_x, dist_neg_x;
  cfg_word_t band_eff;
  logic      zero_pos, zero_neg, scale_pos, scale_neg;

  // slew stage signals
  ext_t delta_x, step_x, delta_c;

  // divider hookup
  logic                 div_start, div_done;
  logic [ProdWidth-1:0] div_dividend;
  logic [MagWidth-1:0]  div_quot;

  tgsl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tgsl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (band_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.setpoint_out = out_q;

  // clamp the request, then classify against the tilt limit and guard band
  assign band_eff  = (cfg.guard_band == '0) ? cfg_word_t'(1) : cfg.guard_band;
  assign req_x     = ext_t'(req_q);
  assign meas_x    = ext_t'(meas_q);
  assign lim_x     = ext_t'(cfg.max_setpoint);
  assign tilt_x    = ext_t'(cfg.max_tilt);
  assign band_x    = ext_t'(band_eff);

  always_comb begin
    raw_x = req_x;
    if (req_x > lim_x) begin
      raw_x = lim_x;
    end else if (req_x < -lim_x) begin
      raw_x = -lim_x;
    end
  end

  assign raw_neg_x  = -raw_x;
  assign zero_pos   = (meas_x >= tilt_x) && (raw_x > ext_t'(0));
  assign zero_neg   = (meas_x <= -tilt_x) && (raw_x < ext_t'(0));
  assign scale_pos  = (meas_x > (tilt_x - band_x)) && (raw_x > ext_t'(0));
  assign scale_neg  = (meas_x < (band_x - tilt_x)) && (raw_x < ext_t'(0));
  assign dist_pos_x = tilt_x - meas_x;
  assign dist_neg_x = meas_x + tilt_x;

  // single multiply, registered inside the divider on start
  assign div_dividend = ProdWidth'(mag_q) * ProdWidth'(dist_q);
  assign div_start    = (state_q == S_MUL);

  // slew limiting toward the guarded value
  assign delta_x = ext_t'(gd_q) - ext_t'(held_q);
  assign step_x  = ext_t'(cfg.step_limit);

  always_comb begin
    delta_c = delta_x;
    if (delta_x > step_x) begin
      delta_c = step_x;
    end else if (delta_x < -step_x) begin
      delta_c = -step_x;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    req_d       = req_q;
    meas_d      = meas_q;
    gd_d        = gd_q;
    held_d      = held_q;
    res_d       = res_q;
    mag_d       = mag_q;
    dist_d      = dist_q;
    neg_d       = neg_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          req_d   = in_i.setpoint_in;
          meas_d  = in_i.pitch_meas;
          state_d = S_GUARD;
        end
      end
      S_GUARD: begin
        if (cfg.bypass) begin
          res_d   = req_q;
          state_d = S_OUT;
        end else if (zero_pos || zero_neg) begin
          gd_d    = '0;
          state_d = S_SLEW;
        end else if (scale_pos) begin
          mag_d   = raw_x[MagWidth-1:0];
          dist_d  = dist_pos_x[CfgWidth-1:0];
          neg_d   = 1'b0;
          state_d = S_MUL;
        end else if (scale_neg) begin
          mag_d   = raw_neg_x[MagWidth-1:0];
          dist_d  = dist_neg_x[CfgWidth-1:0];
          neg_d   = 1'b1;
          state_d = S_MUL;
        end else begin
          gd_d    = angle_t'(raw_x);
          state_d = S_SLEW;
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          // quotient truncates toward zero on magnitude, sign put back after
          gd_d    = neg_q ? -angle_t'({1'b0, div_quot}) : angle_t'({1'b0, div_quot});
          state_d = S_SLEW;
        end
      end
      S_SLEW: begin
        held_d  = held_q + angle_t'(delta_c);
        res_d   = held_d;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    req_q  <= req_d;
    meas_q <= meas_d;
    gd_q   <= gd_d;
    res_q  <= res_d;
    mag_q  <= mag_d;
    dist_q <= dist_d;
    neg_q  <= neg_d;
  end

endmodule
